FILE: rtl/prba_pkg.sv
// Shared types, codes and helpers for the page run bitmap allocator.
// Used by every module in rtl/ except prba_ram; depends on nothing.
package prba_pkg;

  localparam int NUM_PAGES_DEF  = 1024;
  localparam int PAGE_SHIFT_DEF = 12;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int CNT_W     = 11;
  localparam int ADDR_W    = 32;
  localparam int STATUS_W  = 2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_RANGE  = 7'b0001000,
    S_SEARCH = 7'b0010000,
    S_PRIME  = 7'b0100000,
    S_WRITE  = 7'b1000000
  } state_t;

  // Per-word outcome of the first-fit scan
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] bit_idx;
    logic [CNT_W-1:0] run_nxt;
  } scan_res_t;

  function automatic logic [BIT_W-1:0] onehot_index(input logic [WORD_BITS-1:0] oh);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (oh[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/prba_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module prba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/prba_scan.sv
// First-fit scan unit: examines one 32-page bitmap word per use.
// Depends on prba_pkg.
module prba_scan (
  input  logic [prba_pkg::WORD_BITS-1:0] used_i,
  input  logic [prba_pkg::CNT_W-1:0]     count_i,
  input  logic [prba_pkg::CNT_W-1:0]     run_i,
  output prba_pkg::scan_res_t            res_o
);

  always_comb begin
    logic [prba_pkg::WORD_BITS-1:0] win;
    logic [prba_pkg::WORD_BITS-1:0] ge_a;
    logic [prba_pkg::WORD_BITS-1:0] hit_b;
    logic [prba_pkg::WORD_BITS-1:0] hit;
    logic [prba_pkg::WORD_BITS-1:0] hit_low;
    logic [prba_pkg::WORD_BITS-1:0] rev;
    logic [prba_pkg::WORD_BITS-1:0] rev_low;
    logic [prba_pkg::CNT_W-1:0]     cnt_m1;
    logic [prba_pkg::CNT_W-1:0]     need_m1;
    logic [prba_pkg::CNT_W:0]       run_sum;

    cnt_m1  = count_i - prba_pkg::CNT_W'(1);
    // run_i < count_i holds during a search
    need_m1 = count_i - run_i - prba_pkg::CNT_W'(1);

    // win[b]: some page in the count-wide window ending at b is used
    win = '0;
    for (int k = 0; k < prba_pkg::WORD_BITS; k++) begin
      if (prba_pkg::CNT_W'(k) < count_i) begin
        win = win | (used_i << k);
      end
    end

    for (int b = 0; b < prba_pkg::WORD_BITS; b++) begin
      // window fits inside this word
      ge_a[b]  = prba_pkg::CNT_W'(b) >= cnt_m1;
      // bits 0..b free and the run carried in from lower words completes it
      hit_b[b] = !(|(used_i << (prba_pkg::WORD_BITS - 1 - b))) &&
                 (prba_pkg::CNT_W'(b) >= need_m1);
      rev[b]   = used_i[prba_pkg::WORD_BITS - 1 - b];
    end

    hit     = (~win & ge_a) | hit_b;
    hit_low = hit & (~hit + prba_pkg::WORD_BITS'(1));
    rev_low = rev & (~rev + prba_pkg::WORD_BITS'(1));

    if (used_i == '0) begin
      run_sum = {1'b0, run_i} + (prba_pkg::CNT_W + 1)'(prba_pkg::WORD_BITS);
    end else begin
      // free pages above the highest used one
      run_sum = (prba_pkg::CNT_W + 1)'(prba_pkg::onehot_index(rev_low));
    end

    res_o.hit     = |hit;
    res_o.bit_idx = prba_pkg::onehot_index(hit_low);
    res_o.run_nxt = run_sum[prba_pkg::CNT_W-1:0];
  end

endmodule

FILE: rtl/prba_mask.sv
// Builds the bit mask of a page run [lo, hi] that falls into one bitmap word.
// Depends on prba_pkg.
module prba_mask #(
  parameter int AW = 5
) (
  input  logic [AW-1:0]                  word_i,
  input  logic [AW+prba_pkg::BIT_W-1:0]  lo_i,
  input  logic [AW+prba_pkg::BIT_W-1:0]  hi_i,
  output logic [prba_pkg::WORD_BITS-1:0] mask_o
);

  logic [prba_pkg::BIT_W-1:0] lo_bit;
  logic [prba_pkg::BIT_W-1:0] hi_bit;

  always_comb begin
    lo_bit = (word_i == lo_i[AW+prba_pkg::BIT_W-1:prba_pkg::BIT_W]) ?
             lo_i[prba_pkg::BIT_W-1:0] : '0;
    hi_bit = (word_i == hi_i[AW+prba_pkg::BIT_W-1:prba_pkg::BIT_W]) ?
             hi_i[prba_pkg::BIT_W-1:0] : '1;
    mask_o = ({prba_pkg::WORD_BITS{1'b1}} << lo_bit) &
             ({prba_pkg::WORD_BITS{1'b1}} >> (~hi_bit));
  end

endmodule

FILE: rtl/page_run_bitmap_allocator.sv
// First-fit page run allocator over an occupancy bitmap held in a RAM of
// (NUM_PAGES+31)/32 words; depends on prba_pkg, prba_ram, prba_scan, prba_mask.
//
// One transaction at a time. After reset a clearing pass zeroes the bitmap
// word by word, during which in_stall stays high. An allocate scans the
// bitmap words in order until the first fitting run ends (at most the word
// count), then rewrites each word the run touches; a free rewrites each word
// of its run. The single RAM read port, one word per cycle, paces both the
// scan and the rewrite. Requests rejected by the checks never touch the
// bitmap. The result sits in an output register, so a new request is taken
// while the previous result still waits on out_stall.
module page_run_bitmap_allocator #(
  parameter int NUM_PAGES  = prba_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = prba_pkg::PAGE_SHIFT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [prba_pkg::ADDR_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [prba_pkg::CNT_W-1:0]     in_page_count,
  input  logic [prba_pkg::ADDR_W-1:0]    in_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [prba_pkg::STATUS_W-1:0]  out_status,
  output logic [prba_pkg::ADDR_W-1:0]    out_address_out
);

  localparam int NUM_WORDS = (NUM_PAGES + 31) / 32;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PG_W      = AW + prba_pkg::BIT_W;
  localparam int OFF_W     = prba_pkg::ADDR_W - PAGE_SHIFT;
  localparam int SUM_W     = OFF_W + 1;
  localparam int TAIL_BITS = NUM_PAGES - 32 * (NUM_WORDS - 1);
  localparam logic [32:0]   TAIL_ONE  = 33'(1) << TAIL_BITS;
  localparam logic [31:0]   TAIL_MASK = ~(TAIL_ONE[31:0] - 32'd1);
  localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

  prba_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]                  clr_r, clr_nxt;
  logic                           action_r, action_nxt;
  logic [prba_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [prba_pkg::ADDR_W-1:0]    addr_r, addr_nxt;
  logic [OFF_W-1:0]               idx_r, idx_nxt;
  logic [AW-1:0]                  srch_w_r, srch_w_nxt;
  logic [prba_pkg::CNT_W-1:0]     run_r, run_nxt;
  logic [PG_W-1:0]                lo_r, lo_nxt;
  logic [PG_W-1:0]                hi_r, hi_nxt;
  logic [AW-1:0]                  wr_w_r, wr_w_nxt;
  logic [prba_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [prba_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [prba_pkg::ADDR_W-1:0]    out_address_r, out_address_nxt;
  logic [prba_pkg::ADDR_W-1:0]    base_r;
  logic                           finish_r, finish_nxt;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [prba_pkg::WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [prba_pkg::WORD_BITS-1:0] ram_rdata;

  logic [prba_pkg::WORD_BITS-1:0] scan_used;
  prba_pkg::scan_res_t            scan_res;
  logic [prba_pkg::WORD_BITS-1:0] run_mask;

  logic [prba_pkg::ADDR_W:0]      diff;
  logic [SUM_W-1:0]               sum;
  logic [SUM_W-1:0]               sum_m1;
  logic [PG_W-1:0]                end_pg;
  logic [SUM_W-1:0]               lo_wide;

  prba_ram #(
    .WIDTH(prba_pkg::WORD_BITS),
    .DEPTH(NUM_WORDS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // pages past the pool in the last word look used to the scan
  assign scan_used = ram_rdata | ((srch_w_r == LAST_WORD) ? TAIL_MASK : '0);

  prba_scan u_scan (
    .used_i  (scan_used),
    .count_i (count_r),
    .run_i   (run_r),
    .res_o   (scan_res)
  );

  prba_mask #(
    .AW(AW)
  ) u_mask (
    .word_i (wr_w_r),
    .lo_i   (lo_r),
    .hi_i   (hi_r),
    .mask_o (run_mask)
  );

  assign diff    = {1'b0, addr_r} - {1'b0, base_r};
  assign sum     = SUM_W'(idx_r) + SUM_W'(count_r);
  assign sum_m1  = sum - SUM_W'(1);
  assign end_pg  = {srch_w_r, scan_res.bit_idx};
  assign lo_wide = SUM_W'(end_pg) + SUM_W'(1) - SUM_W'(count_r);

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    action_nxt      = action_r;
    count_nxt       = count_r;
    addr_nxt        = addr_r;
    idx_nxt         = idx_r;
    srch_w_nxt      = srch_w_r;
    run_nxt         = run_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    wr_w_nxt        = wr_w_r;
    status_nxt      = status_r;
    finish_nxt      = finish_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_address_nxt = out_address_r;
    ram_we          = 1'b0;
    ram_waddr       = wr_w_r;
    ram_wdata       = '0;
    ram_raddr       = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      prba_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_WORD) begin
          state_nxt = prba_pkg::S_IDLE;
        end
      end
      prba_pkg::S_IDLE: begin
        // deliver a finished result once the output register is free
        if (finish_r && (!out_valid_r || !out_stall)) begin
          finish_nxt      = 1'b0;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_address_nxt = (status_r == prba_pkg::ST_DONE && action_r == prba_pkg::ACT_ALLOC) ?
                            base_r + (32'(lo_r) << PAGE_SHIFT) : '0;
        end else if (!finish_r && in_valid) begin
          action_nxt = in_action;
          count_nxt  = in_page_count;
          addr_nxt   = in_address;
          state_nxt  = prba_pkg::S_CHECK;
        end
      end
      prba_pkg::S_CHECK: begin
        if (count_r == '0) begin
          status_nxt = prba_pkg::ST_BAD;
          finish_nxt = 1'b1;
          state_nxt  = prba_pkg::S_IDLE;
        end else if (action_r == prba_pkg::ACT_ALLOC) begin
          if (SUM_W'(count_r) > SUM_W'(NUM_PAGES)) begin
            status_nxt = prba_pkg::ST_NOSPACE;
            finish_nxt = 1'b1;
            state_nxt  = prba_pkg::S_IDLE;
          end else begin
            ram_raddr  = '0;
            srch_w_nxt = '0;
            run_nxt    = '0;
            state_nxt  = prba_pkg::S_SEARCH;
          end
        end else if (diff[prba_pkg::ADDR_W]) begin
          status_nxt = prba_pkg::ST_BAD;
          finish_nxt = 1'b1;
          state_nxt  = prba_pkg::S_IDLE;
        end else begin
          idx_nxt   = diff[prba_pkg::ADDR_W-1:PAGE_SHIFT];
          state_nxt = prba_pkg::S_RANGE;
        end
      end
      prba_pkg::S_RANGE: begin
        if (sum > SUM_W'(NUM_PAGES)) begin
          status_nxt = prba_pkg::ST_BAD;
          finish_nxt = 1'b1;
          state_nxt  = prba_pkg::S_IDLE;
        end else begin
          lo_nxt    = idx_r[PG_W-1:0];
          hi_nxt    = sum_m1[PG_W-1:0];
          state_nxt = prba_pkg::S_PRIME;
        end
      end
      prba_pkg::S_SEARCH: begin
        ram_raddr = (srch_w_r == LAST_WORD) ? srch_w_r : srch_w_r + AW'(1);
        if (scan_res.hit) begin
          hi_nxt    = end_pg;
          lo_nxt    = lo_wide[PG_W-1:0];
          state_nxt = prba_pkg::S_PRIME;
        end else if (srch_w_r == LAST_WORD) begin
          status_nxt = prba_pkg::ST_NOSPACE;
          finish_nxt = 1'b1;
          state_nxt  = prba_pkg::S_IDLE;
        end else begin
          srch_w_nxt = srch_w_r + AW'(1);
          run_nxt    = scan_res.run_nxt;
        end
      end
      prba_pkg::S_PRIME: begin
        // fetch the first word of the run for read-modify-write
        ram_raddr = lo_r[PG_W-1:prba_pkg::BIT_W];
        wr_w_nxt  = lo_r[PG_W-1:prba_pkg::BIT_W];
        state_nxt = prba_pkg::S_WRITE;
      end
      prba_pkg::S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = wr_w_r;
        ram_wdata = (action_r == prba_pkg::ACT_ALLOC) ? (ram_rdata | run_mask) :
                                                         (ram_rdata & ~run_mask);
        ram_raddr = (wr_w_r == LAST_WORD) ? wr_w_r : wr_w_r + AW'(1);
        if (wr_w_r == hi_r[PG_W-1:prba_pkg::BIT_W]) begin
          status_nxt = prba_pkg::ST_DONE;
          finish_nxt = 1'b1;
          state_nxt  = prba_pkg::S_IDLE;
        end else begin
          wr_w_nxt = wr_w_r + AW'(1);
        end
      end
      default: begin
        state_nxt = prba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prba_pkg::S_CLEAR;
      clr_r       <= '0;
      finish_r    <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      finish_r    <= finish_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    action_r      <= action_nxt;
    count_r       <= count_nxt;
    addr_r        <= addr_nxt;
    idx_r         <= idx_nxt;
    srch_w_r      <= srch_w_nxt;
    run_r         <= run_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    wr_w_r        <= wr_w_nxt;
    status_r      <= status_nxt;
    out_status_r  <= out_status_nxt;
    out_address_r <= out_address_nxt;
  end

  assign in_stall        = (state_r != prba_pkg::S_IDLE) || finish_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_address_out = out_address_r;

  // a failed transaction never reports an address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != prba_pkg::ST_DONE |-> out_address_out == '0)
    else $error("non-zero address on failed transaction");

  // the run update stays inside the run's word span
  a_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == prba_pkg::S_WRITE |->
      wr_w_r >= lo_r[PG_W-1:prba_pkg::BIT_W] && wr_w_r <= hi_r[PG_W-1:prba_pkg::BIT_W])
    else $error("bitmap write outside the run");

  // an allocated or freed run must lie entirely inside the pool
  a_run_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == prba_pkg::S_PRIME |->
      lo_r <= hi_r && SUM_W'(hi_r) < SUM_W'(NUM_PAGES))
    else $error("run out of pool range");

  // a new result is only loaded into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_address_out))
    else $error("pending result overwritten");

endmodule

FILE: verif/page_run_bitmap_allocator_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for page_run_bitmap_allocator: a table of directed requests,
// then random alloc/free traffic over several pool bases, checked by a bitmap predictor.
// Depends on rtl/prba_pkg.sv and rtl/page_run_bitmap_allocator.sv.
module page_run_bitmap_allocator_tb;
  import prba_pkg::*;

  localparam int          NUM_PAGES    = NUM_PAGES_DEF;
  localparam int          PAGE_SHIFT   = PAGE_SHIFT_DEF;
  localparam logic [31:0] DIR_BASE     = 32'h1000_0000;
  localparam int          DIR_ROWS     = 25;
  localparam int          PHASE_ITEMS  = 255;
  localparam int          SETTLE_CYC   = 100;
  localparam int          HOLD_CYC     = 400;
  localparam int          LIMIT_CYCLES = 2_000_000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
  } reply_t;

  typedef struct packed {
    logic                act;
    logic [CNT_W-1:0]    cnt;
    logic [ADDR_W-1:0]   adr;
    logic                has_ref;
    logic [STATUS_W-1:0] ref_status;
    logic [ADDR_W-1:0]   ref_addr;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [ADDR_W-1:0]   cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic                in_action;
  logic [CNT_W-1:0]    in_page_count;
  logic [ADDR_W-1:0]   in_address;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_address_out;

  // side info travelling with the offered request: a typed-in answer, if any
  logic                item_has_ref;
  reply_t              item_ref;

  bit [NUM_PAGES-1:0]  page_map;
  logic [ADDR_W-1:0]   pool_base_model;
  reply_t              replies_due[$];

  int   fault_count;
  int   cycle_count;
  int   n_placed, n_freed, n_nospace, n_rejected;
  bit   steady;
  bit   hold_request;
  bit   hold_seen;
  int   hold_left;
  dir_row_t directed_rows [DIR_ROWS];

  page_run_bitmap_allocator uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_page_count  (in_page_count),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_address_out(out_address_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // First-fit alloc / run free over the predicted bitmap
  function automatic reply_t serve_request(input logic act, input logic [CNT_W-1:0] cnt,
                                           input logic [ADDR_W-1:0] adr);
    reply_t r;
    int run;
    int first;
    logic [ADDR_W-1:0] pg;
    r.status = ST_DONE;
    r.addr   = '0;
    run      = 0;
    first    = -1;
    if (cnt == 0) begin
      r.status = ST_BAD;
    end else if (act == ACT_ALLOC) begin
      if (cnt <= NUM_PAGES) begin
        for (int p = 0; p < NUM_PAGES && first < 0; p++) begin
          if (page_map[p]) begin
            run = 0;
          end else begin
            run++;
            if (run == cnt) first = p + 1 - int'(cnt);
          end
        end
      end
      if (first >= 0) begin
        for (int p = first; p < first + int'(cnt); p++) page_map[p] = 1'b1;
        r.addr = pool_base_model + (32'(first) << PAGE_SHIFT);
      end else begin
        r.status = ST_NOSPACE;
      end
    end else if (adr < pool_base_model) begin
      r.status = ST_BAD;
    end else begin
      pg = (adr - pool_base_model) >> PAGE_SHIFT;
      if (pg > NUM_PAGES || 32'(cnt) > 32'(NUM_PAGES) - pg) begin
        r.status = ST_BAD;
      end else begin
        for (int p = 0; p < int'(cnt); p++) page_map[pg + p] = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic note_fault(input string what, input reply_t want, input reply_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: %s: expected status %0d addr %08h, got status %0d addr %08h",
               $realtime, what, want.status, want.addr, got.status, got.addr);
  endtask

  // Monitor: outputs first so a result never pairs with a request taken on the same edge
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      page_map        = '0;
      pool_base_model = '0;
    end else begin
      if (out_valid && !out_stall) begin
        got.status = out_status;
        got.addr   = out_address_out;
        if (replies_due.size() == 0) begin
          note_fault("result with no request outstanding", '0, got);
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status) note_fault("status mismatch", want, got);
          else if (got.addr !== want.addr) note_fault("address mismatch", want, got);
        end
      end
      if (cfg_wr_en) pool_base_model = cfg_wr_data;
      if (in_valid && !in_stall) begin
        want = serve_request(in_action, in_page_count, in_address);
        case (want.status)
          ST_DONE:    if (in_action == ACT_ALLOC) n_placed++; else n_freed++;
          ST_NOSPACE: n_nospace++;
          default:    n_rejected++;
        endcase
        replies_due.push_back(item_has_ref ? item_ref : want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, replies_due.size());
      $display("page_run_bitmap_allocator test failed");
      $finish;
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (steady) begin
        out_stall = 1'b0;
      end else begin
        out_stall = ($urandom_range(99) < 16);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken
  task automatic offer(input logic act, input logic [CNT_W-1:0] cnt,
                       input logic [ADDR_W-1:0] adr, input logic has_ref, input reply_t rr);
    while (!steady && $urandom_range(99) < 16) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_action     = act;
    in_page_count = cnt;
    in_address    = adr;
    item_has_ref  = has_ref;
    item_ref      = rr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_base(input logic [ADDR_W-1:0] base);
    drain();
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = base;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  task automatic random_phase(input logic [ADDR_W-1:0] base, input bit with_hold,
                              input bit quiet_start);
    logic              act;
    logic [CNT_W-1:0]  cnt;
    logic [ADDR_W-1:0] adr;
    int                sel;
    int                pg;
    int                span;
    write_base(base);
    steady = quiet_start;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (k == 120) steady = 1'b0;
      if (with_hold && k == PHASE_ITEMS / 3) hold_request = 1'b1;
      if (k == PHASE_ITEMS / 2) drain();
      sel = $urandom_range(99);
      pg  = $urandom_range(NUM_PAGES - 1);
      adr = base + (32'(pg) << PAGE_SHIFT) + 32'($urandom_range(4095));
      if (sel < 55) begin
        act = ACT_ALLOC;
        if ($urandom_range(19) == 0) cnt = CNT_W'($urandom_range(2047, 1));
        else cnt = CNT_W'($urandom_range(24, 1));
        adr = $urandom;
      end else if (sel < 88) begin
        act  = ACT_FREE;
        span = NUM_PAGES - pg;
        if (span > 48 && $urandom_range(9) != 0) span = 48;
        cnt  = CNT_W'($urandom_range(span, 1));
      end else if (sel < 94) begin
        // run that just overhangs the end of the pool
        act = ACT_FREE;
        cnt = CNT_W'(NUM_PAGES - pg + $urandom_range(3, 1));
      end else begin
        act = 1'($urandom_range(1));
        cnt = ($urandom_range(2) == 0) ? '0 : CNT_W'($urandom);
        adr = $urandom;
      end
      offer(act, cnt, adr, 1'b0, '0);
    end
    drain();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_action     = ACT_ALLOC;
    in_page_count = '0;
    in_address    = '0;
    item_has_ref  = 1'b0;
    item_ref      = '0;
    steady        = 1'b0;
    hold_request  = 1'b0;
    fault_count   = 0;
    cycle_count   = 0;
    n_placed      = 0;
    n_freed       = 0;
    n_nospace     = 0;
    n_rejected    = 0;

    directed_rows = '{
      '{ACT_ALLOC, 11'd0,    32'h0,                   1'b1, ST_BAD,     32'h0},
      '{ACT_FREE,  11'd0,    DIR_BASE,                1'b1, ST_BAD,     32'h0},
      '{ACT_ALLOC, 11'd1,    32'h0,                   1'b1, ST_DONE,    DIR_BASE},
      '{ACT_ALLOC, 11'd3,    32'h0,                   1'b1, ST_DONE,    DIR_BASE + 32'h1000},
      '{ACT_ALLOC, 11'd1025, 32'h0,                   1'b1, ST_NOSPACE, 32'h0},
      '{ACT_ALLOC, 11'd2047, 32'hFFFF_FFFF,           1'b1, ST_NOSPACE, 32'h0},
      '{ACT_FREE,  11'd1,    DIR_BASE - 32'd1,        1'b1, ST_BAD,     32'h0},
      '{ACT_FREE,  11'd1,    32'h0,                   1'b1, ST_BAD,     32'h0},
      '{ACT_FREE,  11'd2,    DIR_BASE + 32'h3F_F000,  1'b1, ST_BAD,     32'h0},
      '{ACT_FREE,  11'd1,    DIR_BASE + 32'h40_0000,  1'b1, ST_BAD,     32'h0},
      '{ACT_FREE,  11'd1,    32'hFFFF_FFFF,           1'b1, ST_BAD,     32'h0},
      '{ACT_FREE,  11'd1,    DIR_BASE + 32'h1FFF,     1'b1, ST_DONE,    32'h0},
      '{ACT_ALLOC, 11'd1,    32'h0,                   1'b1, ST_DONE,    DIR_BASE + 32'h1000},
      '{ACT_FREE,  11'd10,   DIR_BASE + 32'h1F_4000,  1'b1, ST_DONE,    32'h0},
      '{ACT_FREE,  11'd1024, DIR_BASE,                1'b1, ST_DONE,    32'h0},
      '{ACT_ALLOC, 11'd1024, 32'h0,                   1'b1, ST_DONE,    DIR_BASE},
      '{ACT_ALLOC, 11'd1,    32'h0,                   1'b1, ST_NOSPACE, 32'h0},
      '{ACT_FREE,  11'd20,   DIR_BASE + 32'hA000,     1'b1, ST_DONE,    32'h0},
      '{ACT_ALLOC, 11'd21,   32'h0,                   1'b1, ST_NOSPACE, 32'h0},
      '{ACT_ALLOC, 11'd20,   32'h0,                   1'b1, ST_DONE,    DIR_BASE + 32'hA000},
      '{ACT_FREE,  11'd2047, DIR_BASE,                1'b1, ST_BAD,     32'h0},
      '{ACT_FREE,  11'd1,    DIR_BASE + 32'h3F_F000,  1'b1, ST_DONE,    32'h0},
      '{ACT_ALLOC, 11'd1,    32'h0,                   1'b1, ST_DONE,    DIR_BASE + 32'h3F_F000},
      '{ACT_FREE,  11'd1024, DIR_BASE,                1'b1, ST_DONE,    32'h0},
      '{ACT_ALLOC, 11'd33,   32'h0,                   1'b0, ST_DONE,    32'h0}
    };

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    // bitmap clearing pass keeps in_stall up
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);

    write_base(DIR_BASE);
    for (int i = 0; i < DIR_ROWS; i++) begin
      offer(directed_rows[i].act, directed_rows[i].cnt, directed_rows[i].adr,
            directed_rows[i].has_ref,
            '{directed_rows[i].ref_status, directed_rows[i].ref_addr});
    end

    random_phase(32'h0000_0000, 1'b1, 1'b0);
    random_phase(32'hFFFF_FFFF, 1'b0, 1'b0);
    random_phase(32'hFFFF_F000, 1'b0, 1'b0);
    random_phase($urandom,      1'b0, 1'b1);
    random_phase(32'h0000_1234, 1'b0, 1'b0);
    random_phase(32'h8000_0000, 1'b0, 1'b0);

    drain();
    repeat (SETTLE_CYC) @(negedge clk);
    if (replies_due.size() != 0) fault_count++;

    $display("covered %0d requests over 7 pool bases: %0d runs placed, %0d runs freed,",
             n_placed + n_freed + n_nospace + n_rejected, n_placed, n_freed);
    $display("%0d out-of-space, %0d rejected; %0d mismatches in %0d cycles",
             n_nospace, n_rejected, fault_count, cycle_count);
    if (fault_count == 0) begin
      $display("page_run_bitmap_allocator test passed");
    end else begin
      $display("page_run_bitmap_allocator test failed");
    end
    $finish;
  end

endmodule
